@@ sv/mses_pkg.sv @@
// ----------------------------------------------------------------------------
// mses_pkg
// Shared types and constants of the multi-slot event scheduler.
// ----------------------------------------------------------------------------
package mses_pkg;

  typedef enum logic [1:0] {
    OP_ADVANCE  = 2'd0,
    OP_REGISTER = 2'd1,
    OP_CANCEL   = 2'd2,
    OP_RESET    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_GRANT      = 3'd0,
    KIND_FIRED      = 3'd1,
    KIND_REGISTERED = 3'd2,
    KIND_FULL       = 3'd3,
    KIND_DONE       = 3'd4
  } kind_t;

  localparam int unsigned FIRE_CAP  = 62;
  localparam logic [2:0]  SHIFT_MAX = 3'd4;
  localparam logic signed [31:0] DL_MAX = 32'sh7FFF_FFFF;

  // Write command into the slot table
  typedef struct packed {
    logic               alloc;        // take the lowest free slot
    logic               dis;          // free the slot at dis_idx
    logic               clr_oneshot;  // free every slot with zero period
    logic               dl_we;        // write deadline at the shared index
    logic signed [31:0] dl_data;
    logic signed [31:0] new_deadline;
    logic [30:0]        new_period;
    logic [3:0]         new_owner;
    logic [7:0]         new_tag;
  } tbl_cmd_t;

endpackage

@@ sv/mses_if.sv @@
// ----------------------------------------------------------------------------
// mses_if
// Channel interfaces: request, result and configuration write.
// ----------------------------------------------------------------------------
interface mses_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [30:0] amount;
  logic        repeat_req;
  logic [3:0]  owner;
  logic [7:0]  tag;
  logic [3:0]  slot;
  logic [30:0] cpu_elapsed;

  modport source (output valid, opcode, amount, repeat_req, owner, tag, slot,
                  cpu_elapsed, input ready);
  modport sink   (input valid, opcode, amount, repeat_req, owner, tag, slot,
                  cpu_elapsed, output ready);
endinterface

interface mses_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [34:0]        grant_clocks;
  logic [3:0]         slot_number;
  logic [3:0]         fired_owner;
  logic [7:0]         fired_tag;
  logic signed [31:0] lateness;
  logic [30:0]        left_over;
  logic               last;

  modport source (output valid, kind, grant_clocks, slot_number, fired_owner,
                  fired_tag, lateness, left_over, last, input ready);
  modport sink   (input valid, kind, grant_clocks, slot_number, fired_owner,
                  fired_tag, lateness, left_over, last, output ready);
endinterface

interface mses_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ sv/mses_slot_table.sv @@
// ----------------------------------------------------------------------------
// mses_slot_table
// Slot storage: enable bits, deadlines, periods, owners and tags.
// ----------------------------------------------------------------------------
module mses_slot_table #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned IW = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mses_pkg::tbl_cmd_t     cmd,
  input  logic [IW-1:0]          rw_idx,
  input  logic [IW-1:0]          dis_idx,
  output logic [SLOT_COUNT-1:0]  en,
  output logic                   free_found,
  output logic [IW-1:0]          free_idx,
  output logic signed [31:0]     rd_deadline,
  output logic [30:0]            rd_period,
  output logic [3:0]             rd_owner,
  output logic [7:0]             rd_tag
);
  import mses_pkg::*;

  logic signed [31:0] deadline [SLOT_COUNT];
  logic [30:0]        period   [SLOT_COUNT];
  logic [3:0]         owner    [SLOT_COUNT];
  logic [7:0]         tag      [SLOT_COUNT];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!en[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      en <= '0;
    end else begin
      if (cmd.clr_oneshot) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (period[i] == '0) en[i] <= 1'b0;
        end
      end
      if (cmd.alloc) en[free_idx] <= 1'b1;
      if (cmd.dis) en[dis_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      deadline[free_idx] <= cmd.new_deadline;
      period[free_idx]   <= cmd.new_period;
      owner[free_idx]    <= cmd.new_owner;
      tag[free_idx]      <= cmd.new_tag;
    end
    if (cmd.dl_we) deadline[rw_idx] <= cmd.dl_data;
  end

  assign rd_deadline = deadline[rw_idx];
  assign rd_period   = period[rw_idx];
  assign rd_owner    = owner[rw_idx];
  assign rd_tag      = tag[rw_idx];

endmodule

@@ sv/multi_slot_event_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// multi_slot_event_scheduler_top
// Countdown event table with register, cancel, reset and time advance.
// ----------------------------------------------------------------------------
// A request is taken only while the sequencer is idle and out of reset. Every
// register, cancel and reset walks all SLOT_COUNT slots through one shared
// subtract-and-compare unit, one slot a cycle, to find the earliest deadline;
// a register then gives its result. An advance steps through the accept, the
// grant, the walk that lowers each deadline, a fire check and the done
// result. Each due event adds a fire, a rescan and a fire check, up to 62
// events. An advance that finds events already due skips the grant and the
// walk, one with no live slot skips the walk and one of zero clocks goes
// straight to the done result. Results leave through a single output
// register; the sequencer holds while that register is full and not taken.
// ----------------------------------------------------------------------------
module multi_slot_event_scheduler_top #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic      clk,
  input  logic      rst,
  mses_cfg_if.sink  cfg,
  mses_req_if.sink  req,
  mses_rsp_if.source rsp
);
  import mses_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
  localparam logic [6:0]    SLOT_LIMIT = 7'(SLOT_COUNT);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_RESULT, S_GRANT, S_FIRECHK, S_FIRE, S_DONE
  } state_t;

  state_t state, ret;

  logic [2:0]         shift;
  logic [2:0]         eff_shift;

  // earliest slot
  logic               ev;
  logic signed [31:0] ed;
  logic [IW-1:0]      es;

  // scan walker
  logic [IW-1:0]      idx;
  logic               bv;
  logic signed [31:0] bd;
  logic [IW-1:0]      bs;
  logic [30:0]        sub;

  logic [30:0]        amt;
  logic [30:0]        seg;
  logic [5:0]         fired;
  logic               res_full;
  logic [IW-1:0]      res_slot;

  // output register
  logic               o_valid;
  logic               o_load;
  kind_t              o_kind;
  logic [34:0]        o_clocks;
  logic [3:0]         o_slot;
  logic [3:0]         o_owner;
  logic [7:0]         o_tag;
  logic signed [31:0] o_late;
  logic [30:0]        o_left;
  logic               o_last;

  tbl_cmd_t           cmd;
  logic [IW-1:0]      rw_idx;
  logic [IW-1:0]      dis_idx;
  logic [SLOT_COUNT-1:0] en;
  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic signed [31:0] rd_deadline;
  logic [30:0]        rd_period;
  logic [3:0]         rd_owner;
  logic [7:0]         rd_tag;

  logic               req_fire;
  logic               out_free;
  op_t                req_op;
  logic [31:0]        reg_sum;
  logic signed [31:0] scan_nd;
  logic               scan_take;
  logic signed [32:0] reload_sum;
  logic [30:0]        seg_calc;

  mses_slot_table #(.SLOT_COUNT(SLOT_COUNT), .IW(IW)) u_table (
    .clk, .rst, .cmd, .rw_idx, .dis_idx, .en, .free_found, .free_idx,
    .rd_deadline, .rd_period, .rd_owner, .rd_tag
  );

  assign cfg.ready = !rst;
  assign req.ready = (state == S_IDLE) && !rst;
  assign req_fire  = req.valid && req.ready;
  assign req_op    = op_t'(req.opcode);
  assign out_free  = !o_valid || rsp.ready;
  assign eff_shift = (shift > SHIFT_MAX) ? 3'd0 : shift;

  // load a new result transaction in the result-producing states
  assign o_load = out_free && (state == S_RESULT || state == S_GRANT ||
                               state == S_FIRE || state == S_DONE);

  // registration deadline, saturated
  assign reg_sum = {1'b0, req.amount} + {1'b0, req.cpu_elapsed >> eff_shift};

  // shared subtract-and-compare unit of the scan
  assign scan_nd   = rd_deadline - $signed({1'b0, sub});
  assign scan_take = en[idx] && (!bv || scan_nd < bd);

  assign reload_sum = 33'(rd_deadline) + $signed({2'b00, rd_period});

  // segment up to the earliest deadline
  assign seg_calc = (ev && (ed < $signed({1'b0, req.amount}))) ? ed[30:0] : req.amount;

  assign rw_idx = (state == S_FIRE) ? es : idx;

  always_comb begin
    cmd              = '0;
    dis_idx          = es;
    cmd.new_deadline = reg_sum[31] ? DL_MAX : $signed(reg_sum);
    cmd.new_period   = req.repeat_req ? req.amount : '0;
    cmd.new_owner    = req.owner;
    cmd.new_tag      = req.tag;
    cmd.dl_data      = scan_nd;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          unique case (req_op)
            OP_REGISTER: cmd.alloc = free_found;
            OP_CANCEL: begin
              dis_idx = IW'(req.slot);
              cmd.dis = ({3'b000, req.slot} < SLOT_LIMIT);
            end
            OP_RESET:   cmd.clr_oneshot = 1'b1;
            OP_ADVANCE: ;
          endcase
        end
      end
      S_SCAN: cmd.dl_we = en[idx];
      S_FIRE: begin
        if (out_free) begin
          if (rd_period != '0) begin
            cmd.dl_we   = 1'b1;
            cmd.dl_data = (reload_sum > 33'(DL_MAX)) ? DL_MAX : reload_sum[31:0];
          end else begin
            cmd.dis = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ret     <= S_IDLE;
      shift   <= '0;
      ev      <= 1'b0;
      ed      <= '0;
      es      <= '0;
      o_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) shift <= cfg.data;
      // hold a result until taken, load the next one when free
      o_valid <= o_load || (o_valid && !rsp.ready);

      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            // start a full walk with no offset unless advance says otherwise
            idx <= '0;
            bv  <= 1'b0;
            sub <= '0;
            unique case (req_op)
              OP_REGISTER: begin
                res_full <= !free_found;
                res_slot <= free_idx;
                ret      <= S_RESULT;
                state    <= S_SCAN;
              end
              OP_CANCEL, OP_RESET: begin
                ret   <= S_IDLE;
                state <= S_SCAN;
              end
              OP_ADVANCE: begin
                amt   <= req.amount;
                fired <= '0;
                seg   <= seg_calc;
                if (req.amount == '0) begin
                  state <= S_DONE;
                end else if (ev && ed <= 0) begin
                  state <= S_FIRECHK;
                end else begin
                  state <= S_GRANT;
                end
              end
            endcase
          end
        end

        S_SCAN: begin
          if (scan_take) begin
            bv <= 1'b1;
            bd <= scan_nd;
            bs <= idx;
          end
          if (idx == LAST_IDX) begin
            ev <= bv || scan_take;
            if (scan_take) begin
              ed <= scan_nd;
              es <= idx;
            end else if (bv) begin
              ed <= bd;
              es <= bs;
            end
            state <= ret;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_RESULT: begin
          if (out_free) begin
            o_kind   <= res_full ? KIND_FULL : KIND_REGISTERED;
            o_clocks <= '0;
            o_slot   <= res_full ? 4'd0 : 4'(res_slot);
            o_owner  <= '0;
            o_tag    <= '0;
            o_late   <= '0;
            o_left   <= '0;
            o_last   <= 1'b1;
            state    <= S_IDLE;
          end
        end

        S_GRANT: begin
          if (out_free) begin
            o_kind   <= KIND_GRANT;
            o_clocks <= 35'(seg) << eff_shift;
            o_slot   <= '0;
            o_owner  <= '0;
            o_tag    <= '0;
            o_late   <= '0;
            o_left   <= '0;
            o_last   <= 1'b0;
            amt      <= amt - seg;
            // lower every live deadline by the segment during a fresh walk
            if (ev) begin
              sub   <= seg;
              idx   <= '0;
              bv    <= 1'b0;
              ret   <= S_FIRECHK;
              state <= S_SCAN;
            end else begin
              state <= S_FIRECHK;
            end
          end
        end

        S_FIRECHK: begin
          if (ev && ed <= 0 && fired < 6'(FIRE_CAP)) begin
            state <= S_FIRE;
          end else begin
            state <= S_DONE;
          end
        end

        S_FIRE: begin
          if (out_free) begin
            o_kind   <= KIND_FIRED;
            o_clocks <= '0;
            o_slot   <= 4'(es);
            o_owner  <= rd_owner;
            o_tag    <= rd_tag;
            o_late   <= rd_deadline;
            o_left   <= '0;
            o_last   <= 1'b0;
            fired    <= fired + 1'b1;
            sub      <= '0;
            idx      <= '0;
            bv       <= 1'b0;
            ret      <= S_FIRECHK;
            state    <= S_SCAN;
          end
        end

        S_DONE: begin
          if (out_free) begin
            o_kind   <= KIND_DONE;
            o_clocks <= '0;
            o_slot   <= '0;
            o_owner  <= '0;
            o_tag    <= '0;
            o_late   <= '0;
            o_left   <= amt;
            o_last   <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.kind         = o_kind;
  assign rsp.grant_clocks = o_clocks;
  assign rsp.slot_number  = o_slot;
  assign rsp.fired_owner  = o_owner;
  assign rsp.fired_tag    = o_tag;
  assign rsp.lateness     = o_late;
  assign rsp.left_over    = o_left;
  assign rsp.last         = o_last;

endmodule
